[rtl/mer_pkg.sv]
// Shared widths, register indexes and controller/datapath interface types.
package mer_pkg;

  localparam int RADIUS_BITS  = 10;
  localparam int COORD_BITS   = 11;
  localparam int OUT_BITS     = COORD_BITS + 2;
  localparam int CFG_BITS     = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int CFG_IDX_BITS = 2;
  localparam int SQ_BITS      = 2 * RADIUS_BITS;
  localparam int OY_BITS      = RADIUS_BITS + 1;
  localparam int TX_BITS      = RADIUS_BITS + 1;
  localparam int TY_BITS      = OY_BITS + 1;
  localparam int MUL_BITS     = 2 * TX_BITS;
  localparam int PROD_BITS    = 2 * MUL_BITS;
  localparam int SLOPE_BITS   = 3 * RADIUS_BITS + 2;
  localparam int DEC_BITS     = PROD_BITS + 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_X = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_Y = 2'd3;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_MUL_START,
    DP_LOAD,
    DP_STEP,
    DP_SETTLE,
    DP_SW_TX,
    DP_SW_TY,
    DP_SW_A,
    DP_SW_B,
    DP_SW_C,
    DP_SW_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   capture;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic need_switch;
  } dp_status_t;

endpackage

[rtl/mer_datapath.sv]
// Datapath: configuration, walk state, shared multiplier and result register.
module mer_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mer_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mer_pkg::CFG_BITS-1:0]         cfg_data,
  input  mer_pkg::dp_cmd_t                     cmd,
  output mer_pkg::dp_status_t                  status,
  output logic                                 valid_res,
  output logic signed [mer_pkg::OUT_BITS-1:0]  x_right,
  output logic signed [mer_pkg::OUT_BITS-1:0]  x_left,
  output logic signed [mer_pkg::OUT_BITS-1:0]  y_below,
  output logic signed [mer_pkg::OUT_BITS-1:0]  y_above,
  output logic                                 in_region_two,
  output logic                                 last
);

  logic [mer_pkg::COORD_BITS-1:0]         center_x, center_y;
  logic [mer_pkg::RADIUS_BITS-1:0]        radius_x, radius_y;
  logic [mer_pkg::SQ_BITS-1:0]            rx2, ry2, rx2_c, ry2_c;

  logic [mer_pkg::RADIUS_BITS-1:0]        offset_x, offset_x_next;
  logic signed [mer_pkg::OY_BITS-1:0]     offset_y, offset_y_next;
  logic signed [mer_pkg::SLOPE_BITS-1:0]  slope_x, slope_x_next, slope_y, slope_y_next;
  logic signed [mer_pkg::DEC_BITS-1:0]    decision, decision_next;
  logic                                   region, finished;

  logic [mer_pkg::MUL_BITS-1:0]           mul_a, mul_b, t1, t2;
  logic [mer_pkg::PROD_BITS-1:0]          mul_p, prod;
  logic signed [mer_pkg::DEC_BITS-1:0]    acc, prod4, prod1;

  logic [mer_pkg::TX_BITS-1:0]            tx;
  logic signed [mer_pkg::TY_BITS-1:0]     ty, ty_neg;
  logic [mer_pkg::OY_BITS-1:0]            ty_abs;

  logic signed [mer_pkg::SLOPE_BITS-1:0]  two_rx2, two_ry2, sx_inc, sy_dec;
  logic signed [mer_pkg::DEC_BITS-1:0]    dsx, dsy, rx2_d, ry2_d;

  assign rx2_c = radius_x * radius_x;
  assign ry2_c = radius_y * radius_y;

  assign tx     = {offset_x, 1'b1};
  assign ty     = mer_pkg::TY_BITS'(offset_y) - mer_pkg::TY_BITS'(1);
  assign ty_neg = -ty;
  assign ty_abs = ty[mer_pkg::TY_BITS-1] ? ty_neg[mer_pkg::OY_BITS-1:0]
                                         : ty[mer_pkg::OY_BITS-1:0];

  assign prod4 = signed'({prod, 2'b00});
  assign prod1 = signed'({{(mer_pkg::DEC_BITS-mer_pkg::PROD_BITS){1'b0}}, prod});

  assign two_rx2 = signed'({{(mer_pkg::SLOPE_BITS-mer_pkg::SQ_BITS-1){1'b0}}, rx2, 1'b0});
  assign two_ry2 = signed'({{(mer_pkg::SLOPE_BITS-mer_pkg::SQ_BITS-1){1'b0}}, ry2, 1'b0});
  assign sx_inc  = slope_x + two_ry2;
  assign sy_dec  = slope_y - two_rx2;
  assign dsx     = mer_pkg::DEC_BITS'(sx_inc);
  assign dsy     = mer_pkg::DEC_BITS'(sy_dec);
  assign rx2_d   = signed'({{(mer_pkg::DEC_BITS-mer_pkg::SQ_BITS){1'b0}}, rx2});
  assign ry2_d   = signed'({{(mer_pkg::DEC_BITS-mer_pkg::SQ_BITS){1'b0}}, ry2});

  assign status.finished    = finished;
  assign status.need_switch = !finished && !region && !(slope_x < slope_y);

  // shared multiplier operand select
  always_comb begin
    case (cmd.op)
      mer_pkg::DP_MUL_START: begin
        mul_a = mer_pkg::MUL_BITS'(rx2);
        mul_b = mer_pkg::MUL_BITS'(radius_y);
      end
      mer_pkg::DP_SW_TX: begin
        mul_a = mer_pkg::MUL_BITS'(tx);
        mul_b = mer_pkg::MUL_BITS'(tx);
      end
      mer_pkg::DP_SW_TY: begin
        mul_a = mer_pkg::MUL_BITS'(ty_abs);
        mul_b = mer_pkg::MUL_BITS'(ty_abs);
      end
      mer_pkg::DP_SW_A: begin
        mul_a = mer_pkg::MUL_BITS'(ry2);
        mul_b = t1;
      end
      mer_pkg::DP_SW_B: begin
        mul_a = mer_pkg::MUL_BITS'(rx2);
        mul_b = t2;
      end
      mer_pkg::DP_SW_C: begin
        mul_a = mer_pkg::MUL_BITS'(rx2);
        mul_b = mer_pkg::MUL_BITS'(ry2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // one midpoint step
  always_comb begin
    offset_x_next = offset_x;
    offset_y_next = offset_y;
    slope_x_next  = slope_x;
    slope_y_next  = slope_y;
    decision_next = decision;
    if (!region) begin
      offset_x_next = offset_x + 1'b1;
      slope_x_next  = sx_inc;
      if (decision[mer_pkg::DEC_BITS-1]) begin
        decision_next = decision + ((dsx + ry2_d) <<< 2);
      end else begin
        offset_y_next = offset_y - 1'b1;
        slope_y_next  = sy_dec;
        decision_next = decision + ((dsx - dsy + ry2_d) <<< 2);
      end
    end else begin
      offset_y_next = offset_y - 1'b1;
      slope_y_next  = sy_dec;
      if (!decision[mer_pkg::DEC_BITS-1] && (decision != '0)) begin
        decision_next = decision + ((rx2_d - dsy) <<< 2);
      end else begin
        offset_x_next = offset_x + 1'b1;
        slope_x_next  = sx_inc;
        decision_next = decision + ((dsx - dsy + rx2_d) <<< 2);
      end
    end
  end

  always_ff @(posedge clk) begin
    rx2  <= rx2_c;
    ry2  <= ry2_c;
    prod <= mul_p;
    case (cmd.op)
      mer_pkg::DP_SW_TY: t1  <= prod[mer_pkg::MUL_BITS-1:0];
      mer_pkg::DP_SW_A:  t2  <= prod[mer_pkg::MUL_BITS-1:0];
      mer_pkg::DP_SW_B:  acc <= prod1;
      mer_pkg::DP_SW_C:  acc <= acc + prod4;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      radius_x      <= mer_pkg::RADIUS_BITS'(1);
      radius_y      <= mer_pkg::RADIUS_BITS'(1);
      offset_x      <= '0;
      offset_y      <= '0;
      slope_x       <= '0;
      slope_y       <= '0;
      decision      <= '0;
      region        <= 1'b0;
      finished      <= 1'b1;
      valid_res     <= 1'b0;
      x_right       <= '0;
      x_left        <= '0;
      y_below       <= '0;
      y_above       <= '0;
      in_region_two <= 1'b0;
      last          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mer_pkg::CFG_CENTER_X: center_x <= cfg_data[mer_pkg::COORD_BITS-1:0];
          mer_pkg::CFG_CENTER_Y: center_y <= cfg_data[mer_pkg::COORD_BITS-1:0];
          mer_pkg::CFG_RADIUS_X: radius_x <= cfg_data[mer_pkg::RADIUS_BITS-1:0];
          mer_pkg::CFG_RADIUS_Y: radius_y <= cfg_data[mer_pkg::RADIUS_BITS-1:0];
          default: ;
        endcase
      end

      if (cmd.capture) begin
        if (finished) begin
          valid_res     <= 1'b0;
          x_right       <= '0;
          x_left        <= '0;
          y_below       <= '0;
          y_above       <= '0;
          in_region_two <= 1'b0;
          last          <= 1'b0;
        end else begin
          valid_res     <= 1'b1;
          x_right       <= mer_pkg::OUT_BITS'(center_x) + mer_pkg::OUT_BITS'(offset_x);
          x_left        <= mer_pkg::OUT_BITS'(center_x) - mer_pkg::OUT_BITS'(offset_x);
          y_below       <= mer_pkg::OUT_BITS'(center_y) + mer_pkg::OUT_BITS'(offset_y);
          y_above       <= mer_pkg::OUT_BITS'(center_y) - mer_pkg::OUT_BITS'(offset_y);
          in_region_two <= region;
          last          <= (offset_y == '0);
        end
      end

      case (cmd.op)
        mer_pkg::DP_LOAD: begin
          offset_x <= '0;
          offset_y <= signed'({1'b0, radius_y});
          slope_x  <= '0;
          slope_y  <= signed'({prod[mer_pkg::SLOPE_BITS-2:0], 1'b0});
          decision <= signed'({{(mer_pkg::DEC_BITS-mer_pkg::SQ_BITS-2){1'b0}}, ry2, 2'b00})
                      - prod4 + rx2_d;
          region   <= 1'b0;
          finished <= 1'b0;
        end
        mer_pkg::DP_STEP: begin
          offset_x <= offset_x_next;
          offset_y <= offset_y_next;
          slope_x  <= slope_x_next;
          slope_y  <= slope_y_next;
          decision <= decision_next;
        end
        mer_pkg::DP_SETTLE: begin
          if (offset_y[mer_pkg::OY_BITS-1]) finished <= 1'b1;
        end
        mer_pkg::DP_SW_FIN: begin
          decision <= acc - prod4;
          region   <= 1'b1;
          if (offset_y[mer_pkg::OY_BITS-1]) finished <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/mer_controller.sv]
// Controller: sequences start, step, region change and output beats.
module mer_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                restart,
  output logic                out_valid,
  input  logic                out_ready,
  input  mer_pkg::dp_status_t status,
  output mer_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_MUL,
    S_START_LOAD,
    S_EMIT,
    S_SETTLE,
    S_SW_TY,
    S_SW_A,
    S_SW_B,
    S_SW_C,
    S_SW_FIN
  } state_t;

  state_t state, state_next;
  logic   from_start;
  logic   emit_ok;

  assign in_ready = (state == S_IDLE);
  assign emit_ok  = !out_valid || out_ready;

  always_comb begin
    cmd.op      = mer_pkg::DP_NOP;
    cmd.capture = 1'b0;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = restart ? S_START_MUL : S_EMIT;
      end
      S_START_MUL: begin
        cmd.op     = mer_pkg::DP_MUL_START;
        state_next = S_START_LOAD;
      end
      S_START_LOAD: begin
        cmd.op     = mer_pkg::DP_LOAD;
        state_next = S_SETTLE;
      end
      S_EMIT: begin
        if (emit_ok) begin
          cmd.capture = 1'b1;
          if (status.finished) begin
            state_next = S_IDLE;
          end else begin
            cmd.op     = mer_pkg::DP_STEP;
            state_next = S_SETTLE;
          end
        end
      end
      S_SETTLE: begin
        if (status.need_switch) begin
          cmd.op     = mer_pkg::DP_SW_TX;
          state_next = S_SW_TY;
        end else begin
          cmd.op     = mer_pkg::DP_SETTLE;
          state_next = from_start ? S_EMIT : S_IDLE;
        end
      end
      S_SW_TY: begin
        cmd.op     = mer_pkg::DP_SW_TY;
        state_next = S_SW_A;
      end
      S_SW_A: begin
        cmd.op     = mer_pkg::DP_SW_A;
        state_next = S_SW_B;
      end
      S_SW_B: begin
        cmd.op     = mer_pkg::DP_SW_B;
        state_next = S_SW_C;
      end
      S_SW_C: begin
        cmd.op     = mer_pkg::DP_SW_C;
        state_next = S_SW_FIN;
      end
      S_SW_FIN: begin
        cmd.op     = mer_pkg::DP_SW_FIN;
        state_next = from_start ? S_EMIT : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      from_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) from_start <= restart;
      if (cmd.capture) begin
        out_valid  <= 1'b1;
        from_start <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/midpoint_ellipse_rasterizer_unit.sv]
// Top level of the midpoint ellipse rasterizer.
// Use: write center and radii on the cfg channel (cfg_index 0..3: center_x,
// center_y, radius_x, radius_y; cfg_ready is always high). Each input beat
// carries restart: 1 starts a new ellipse at its top point, 0 takes the next
// point. Every input beat gives exactly one output beat with the four mirror
// points; valid_res is 0 (all other fields 0) once the ellipse is finished.
// Sequence: an input beat is taken in the idle state. A plain step passes the
// states accept, emit and step, settle, and its result is registered in the
// emit state; a restart adds the states start product, load and settle ahead
// of the emit; the switch to region two adds the states SW_TY, SW_A, SW_B,
// SW_C and SW_FIN, set by the one shared multiplier that forms the region-two
// decision term by term.
// Results sit in an output register: after a beat is emitted the controller
// finishes the step and takes the next input while the result waits. If the
// receiver stalls, the next item waits in its emit state until the register
// is free. Reset (rst, synchronous) clears the walk to finished, loads center
// 0 and radii 1, and empties the output register.
module midpoint_ellipse_rasterizer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mer_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mer_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 valid_res,
  output logic signed [mer_pkg::OUT_BITS-1:0]  x_right,
  output logic signed [mer_pkg::OUT_BITS-1:0]  x_left,
  output logic signed [mer_pkg::OUT_BITS-1:0]  y_below,
  output logic signed [mer_pkg::OUT_BITS-1:0]  y_above,
  output logic                                 in_region_two,
  output logic                                 last
);

  mer_pkg::dp_cmd_t    cmd;
  mer_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  mer_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mer_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .status        (status),
    .valid_res     (valid_res),
    .x_right       (x_right),
    .x_left        (x_left),
    .y_below       (y_below),
    .y_above       (y_above),
    .in_region_two (in_region_two),
    .last          (last)
  );

endmodule

[rtl/mer_checker.sv]
// Port-level assertions for the rasterizer, bound to the top level.
module mer_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 valid_res,
  input logic signed [mer_pkg::OUT_BITS-1:0]  x_right,
  input logic signed [mer_pkg::OUT_BITS-1:0]  x_left,
  input logic signed [mer_pkg::OUT_BITS-1:0]  y_below,
  input logic signed [mer_pkg::OUT_BITS-1:0]  y_above,
  input logic                                 last
);

  a_reset_clears: assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("output beat or busy input after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item still in work");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |->
      (x_right == '0 && x_left == '0 && y_below == '0 && y_above == '0 && !last))
    else $error("finished beat carries non-zero fields");

  a_last_on_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res && last |-> (y_below == y_above))
    else $error("last point set not on the horizontal axis");

endmodule

bind midpoint_ellipse_rasterizer_unit mer_checker u_mer_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .valid_res (valid_res),
  .x_right   (x_right),
  .x_left    (x_left),
  .y_below   (y_below),
  .y_above   (y_above),
  .last      (last)
);

[bench/testbench.sv]
// Self-checking testbench for the midpoint ellipse rasterizer unit.
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 550;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic                         valid_res;
    logic [mer_pkg::OUT_BITS-1:0] x_right;
    logic [mer_pkg::OUT_BITS-1:0] x_left;
    logic [mer_pkg::OUT_BITS-1:0] y_below;
    logic [mer_pkg::OUT_BITS-1:0] y_above;
    logic                         in_region_two;
    logic                         last;
  } point_set_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [mer_pkg::CFG_IDX_BITS-1:0]    cfg_index;
  logic [mer_pkg::CFG_BITS-1:0]        cfg_data;
  logic                                in_valid;
  logic                                in_ready;
  logic                                restart;
  logic                                out_valid;
  logic                                out_ready;
  logic                                valid_res;
  logic signed [mer_pkg::OUT_BITS-1:0] x_right;
  logic signed [mer_pkg::OUT_BITS-1:0] x_left;
  logic signed [mer_pkg::OUT_BITS-1:0] y_below;
  logic signed [mer_pkg::OUT_BITS-1:0] y_above;
  logic                                in_region_two;
  logic                                last;

  midpoint_ellipse_rasterizer_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .restart       (restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .valid_res     (valid_res),
    .x_right       (x_right),
    .x_left        (x_left),
    .y_below       (y_below),
    .y_above       (y_above),
    .in_region_two (in_region_two),
    .last          (last)
  );

  // register shadow
  logic [mer_pkg::COORD_BITS-1:0]  centre_x = '0;
  logic [mer_pkg::COORD_BITS-1:0]  centre_y = '0;
  logic [mer_pkg::RADIUS_BITS-1:0] semi_x = mer_pkg::RADIUS_BITS'(1);
  logic [mer_pkg::RADIUS_BITS-1:0] semi_y = mer_pkg::RADIUS_BITS'(1);

  // walk state
  int unsigned walk_x = 0;
  int          walk_y = 0;
  longint      slope_x = 0;
  longint      slope_y = 0;
  longint      decision = 0;
  bit          walk_region_two = 1'b0;
  bit          walk_done = 1'b1;

  logic       restart_queue[$];
  point_set_t pending_point_sets[$];
  int         beat_count = 0;
  int         error_count = 0;
  int         cycle_count = 0;
  bit         in_fire = 1'b0;
  int         in_gap = 0;
  bit         in_burst = 1'b0;
  int         out_stall = 0;
  bit         out_burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("midpoint_ellipse_rasterizer_unit test failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= 50) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [mer_pkg::OUT_BITS-1:0] got,
                             logic [mer_pkg::OUT_BITS-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s got %0d expected %0d", beat_count, name, got, want));
  endtask

  task automatic settle_walk();
    longint rx2, ry2, tx, ty;
    rx2 = longint'(semi_x) * longint'(semi_x);
    ry2 = longint'(semi_y) * longint'(semi_y);
    if (!walk_done) begin
      if (!walk_region_two && !(slope_x < slope_y)) begin
        tx = 2 * longint'(walk_x) + 1;
        ty = longint'(walk_y) - 1;
        walk_region_two = 1'b1;
        decision = ry2 * tx * tx + 4 * rx2 * ty * ty - 4 * rx2 * ry2;
      end
      if (walk_y < 0) walk_done = 1'b1;
    end
  endtask

  task automatic next_point_set(input logic rs, output point_set_t p);
    longint rx2, ry2;
    rx2 = longint'(semi_x) * longint'(semi_x);
    ry2 = longint'(semi_y) * longint'(semi_y);
    if (rs) begin
      walk_x = 0;
      walk_y = int'(semi_y);
      slope_x = 0;
      slope_y = 2 * rx2 * longint'(semi_y);
      decision = 4 * ry2 - 4 * rx2 * longint'(semi_y) + rx2;
      walk_region_two = 1'b0;
      walk_done = 1'b0;
      settle_walk();
    end
    p = '0;
    if (!walk_done) begin
      p.valid_res     = 1'b1;
      p.x_right       = mer_pkg::OUT_BITS'(int'(centre_x) + int'(walk_x));
      p.x_left        = mer_pkg::OUT_BITS'(int'(centre_x) - int'(walk_x));
      p.y_below       = mer_pkg::OUT_BITS'(int'(centre_y) + walk_y);
      p.y_above       = mer_pkg::OUT_BITS'(int'(centre_y) - walk_y);
      p.in_region_two = walk_region_two;
      p.last          = (walk_y == 0);
      if (!walk_region_two) begin
        walk_x++;
        slope_x += 2 * ry2;
        if (decision < 0) begin
          decision += 4 * (slope_x + ry2);
        end else begin
          walk_y--;
          slope_y -= 2 * rx2;
          decision += 4 * (slope_x - slope_y + ry2);
        end
      end else begin
        walk_y--;
        slope_y -= 2 * rx2;
        if (decision > 0) begin
          decision += 4 * (rx2 - slope_y);
        end else begin
          walk_x++;
          slope_x += 2 * ry2;
          decision += 4 * (slope_x - slope_y + rx2);
        end
      end
      settle_walk();
    end
  endtask

  // monitor
  always @(posedge clk) begin
    point_set_t want;
    point_set_t got;
    in_fire = !rst && in_valid && in_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mer_pkg::CFG_CENTER_X: centre_x = cfg_data[mer_pkg::COORD_BITS-1:0];
          mer_pkg::CFG_CENTER_Y: centre_y = cfg_data[mer_pkg::COORD_BITS-1:0];
          mer_pkg::CFG_RADIUS_X: semi_x = cfg_data[mer_pkg::RADIUS_BITS-1:0];
          mer_pkg::CFG_RADIUS_Y: semi_y = cfg_data[mer_pkg::RADIUS_BITS-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        next_point_set(restart, want);
        pending_point_sets.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{valid_res, x_right, x_left, y_below, y_above, in_region_two, last};
        if (pending_point_sets.size() == 0) begin
          report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_count));
        end else begin
          want = pending_point_sets.pop_front();
          check_field("valid_res", mer_pkg::OUT_BITS'(got.valid_res),
                      mer_pkg::OUT_BITS'(want.valid_res));
          check_field("x_right", got.x_right, want.x_right);
          check_field("x_left", got.x_left, want.x_left);
          check_field("y_below", got.y_below, want.y_below);
          check_field("y_above", got.y_above, want.y_above);
          check_field("in_region_two", mer_pkg::OUT_BITS'(got.in_region_two),
                      mer_pkg::OUT_BITS'(want.in_region_two));
          check_field("last", mer_pkg::OUT_BITS'(got.last), mer_pkg::OUT_BITS'(want.last));
        end
        beat_count++;
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (restart_queue.size() != 0) begin
        restart <= restart_queue.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 99) < 3) in_burst = !in_burst;
        in_gap = in_burst ? 0 : gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 2) out_burst = !out_burst;
      if (!out_burst && $urandom_range(0, 3) == 0) out_stall = gap_len();
    end
  end

  task automatic wait_idle();
    while (restart_queue.size() != 0 || in_valid || pending_point_sets.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [mer_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [mer_pkg::CFG_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(int cx, int cy, int rx, int ry, logic [3:0] mask);
    if (mask != 0) begin
      if (mask[0]) write_reg(mer_pkg::CFG_CENTER_X, mer_pkg::CFG_BITS'(cx));
      if (mask[1]) write_reg(mer_pkg::CFG_CENTER_Y, mer_pkg::CFG_BITS'(cy));
      if (mask[2]) write_reg(mer_pkg::CFG_RADIUS_X, mer_pkg::CFG_BITS'(rx));
      if (mask[3]) write_reg(mer_pkg::CFG_RADIUS_Y, mer_pkg::CFG_BITS'(ry));
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
  endtask

  task automatic queue_walk(logic first, int n);
    restart_queue.push_back(first);
    repeat (n - 1) restart_queue.push_back(1'b0);
  endtask

  function automatic int pick_centre();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return (1 << mer_pkg::COORD_BITS) - 1;
    return $urandom_range(0, (1 << mer_pkg::COORD_BITS) - 1);
  endfunction

  function automatic int pick_radius();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 8) return (1 << mer_pkg::RADIUS_BITS) - 1;
    if (r < 15) return $urandom_range(1, (1 << mer_pkg::RADIUS_BITS) - 1);
    return $urandom_range(1, 20);
  endfunction

  initial begin
    int issued;
    int n;
    int r;
    int rx;
    int ry;
    logic [3:0] mask;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = mer_pkg::CFG_CENTER_X;
    cfg_data  = '0;
    in_valid  = 1'b0;
    restart   = 1'b0;
    out_ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // never started, then unit circle at the origin
    queue_walk(1'b0, 2);
    queue_walk(1'b1, 4);
    wait_idle();
    // top corner: coordinates beyond the coordinate range
    configure(2047, 2047, 3, 2, 4'hF);
    queue_walk(1'b1, 8);
    wait_idle();
    // zero horizontal radius: vertical run, negative rows
    configure(0, 0, 0, 2, 4'hF);
    queue_walk(1'b1, 5);
    wait_idle();
    // zero vertical radius: centre row once
    configure(0, 0, 3, 0, 4'hC);
    queue_walk(1'b1, 3);

    issued = 0;
    rx = 3;
    ry = 0;
    while (issued < RANDOM_ITEMS) begin
      wait_idle();
      mask = $urandom_range(0, 3) == 0 ? 4'h0 : 4'($urandom_range(1, 15));
      if (mask[2]) rx = pick_radius();
      if (mask[3]) ry = pick_radius();
      configure(pick_centre(), pick_centre(), rx, ry, mask);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // carry on the current walk under the new settings
        n = $urandom_range(1, 12);
        queue_walk(1'b0, n);
      end else if (r < 22) begin
        n = $urandom_range(3, 15);
        repeat (n) restart_queue.push_back(1'($urandom_range(0, 1)));
      end else begin
        n = rx + ry + $urandom_range(2, 4);
        if (n > 60) n = $urandom_range(20, 60);
        queue_walk(1'b1, n);
      end
      issued += n;
    end
    wait_idle();

    if (error_count == 0) begin
      $display("midpoint_ellipse_rasterizer_unit test passed");
    end else begin
      $display("midpoint_ellipse_rasterizer_unit test failed");
    end
    $finish;
  end

endmodule
